@@ rtl/rkvs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rkvs_pkg: shared types and constants for the rotary knob volume selector
// Event codes, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package rkvs_pkg;

  // Default module parameters
  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PC_W    = 6;
  localparam int unsigned RG_W    = 8;
  localparam int unsigned BG_W    = 10;
  localparam int unsigned VOL_W   = 7;
  localparam int unsigned SEL_W   = 6;
  localparam int unsigned SELO_W  = 5;
  localparam int unsigned CFGI_W  = 2;
  localparam int unsigned CFGD_W  = 10;

  // Remainder unit: one dividend bit per step
  localparam int unsigned DVD_W     = 7;
  localparam int unsigned DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'(DVD_W - 1);

  // Reset values and limits
  localparam logic [RG_W-1:0]  ROT_GUARD_RST = 8'd2;
  localparam logic [BG_W-1:0]  BTN_GUARD_RST = 10'd50;
  localparam logic [VOL_W-1:0] VOL_STEP_RST  = 7'd5;
  localparam logic [VOL_W-1:0] VOL_RST       = 7'd50;
  localparam logic [VOL_W-1:0] VOL_MAX       = 7'd100;

  // Event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TURN  = 2'd0,
    KIND_PRESS = 2'd1,
    KIND_POLL  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFGI_W-1:0] {
    CFG_PLAYLIST_COUNT = 2'd0,
    CFG_ROTATE_GUARD   = 2'd1,
    CFG_BUTTON_GUARD   = 2'd2,
    CFG_VOLUME_STEP    = 2'd3
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_step;
    logic post;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
  } dp_stat_t;

endpackage : rkvs_pkg
`default_nettype wire

@@ rtl/rkvs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rkvs_ctrl: event sequencer
// Runs accept, execute, optional remainder steps, press handling and result
// transfer, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module rkvs_ctrl
  import rkvs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_POST = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cnt_nxt  = '0;
        state_nxt = stat.need_div ? ST_DIV : ST_POST;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        cmd.post  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule : rkvs_ctrl
`default_nettype wire

@@ rtl/rkvs_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rkvs_dp: knob state datapath
// Holds configuration, encoder and playback state, a bit-serial remainder
// unit for the circular selection step, and the result register.
// ----------------------------------------------------------------------------
module rkvs_dp
  import rkvs_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  input  wire logic                    cfg_we,
  input  wire logic [CFGI_W-1:0]       cfg_index,
  input  wire logic [CFGD_W-1:0]       cfg_wdata,
  input  wire logic [KIND_W-1:0]       in_kind,
  input  wire logic [TIME_W-1:0]       in_now_ms,
  input  wire logic                    in_clk_level,
  input  wire logic                    in_dt_level,
  output logic [VOL_W-1:0]             out_volume_now,
  output logic [SELO_W-1:0]            out_selection_now,
  output logic                         out_playing_now,
  output logic signed [COUNT_BITS-1:0] out_knob_count,
  output logic                         out_start_request,
  output logic                         out_stop_request,
  output logic                         out_refresh
);

  localparam int unsigned N_CLAMP = (MAX_ENTRIES > 63) ? 63 : MAX_ENTRIES;
  localparam logic [PC_W-1:0] N_MAX = PC_W'(N_CLAMP);

  // Configuration
  logic [PC_W-1:0]  pc_r;
  logic [RG_W-1:0]  rguard_r;
  logic [BG_W-1:0]  bguard_r;
  logic [VOL_W-1:0] vstep_r;

  // Captured event
  kind_t             kind_r;
  logic [TIME_W-1:0] now_r;
  logic              clk_lv_r;
  logic              dt_lv_r;

  // Knob state
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] polled_r;
  logic                  prev_clk_r;
  logic [TIME_W-1:0]     turn_time_r;
  logic [TIME_W-1:0]     press_time_r;
  logic                  pending_r;
  logic [VOL_W-1:0]      vol_r;
  logic [SEL_W-1:0]      sel_r;
  logic                  playing_r;

  // Per-event flags
  logic start_r, stop_r, refresh_r, div_pend_r;

  // Remainder unit
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] rem_r;

  // Combinational helpers
  logic [TIME_W-1:0]     turn_diff, press_diff;
  logic [COUNT_BITS-1:0] pos_diff;
  logic                  moved, down;
  logic [PC_W-1:0]       n_lim, n_eff;
  logic [VOL_W:0]        vol_up;
  logic [DVD_W-1:0]      shifted;
  logic [SEL_W-1:0]      sel_cur;

  assign turn_diff  = now_r - turn_time_r;
  assign press_diff = now_r - press_time_r;
  assign pos_diff   = count_r - polled_r;
  assign moved      = (pos_diff != '0);
  assign down       = pos_diff[COUNT_BITS-1];
  assign n_lim      = (pc_r > N_MAX) ? N_MAX : pc_r;
  assign n_eff      = (n_lim == '0) ? PC_W'(1) : n_lim;
  assign vol_up     = {1'b0, vol_r} + {1'b0, vstep_r};
  assign shifted    = {rem_r[DVD_W-2:0], dvd_r[DVD_W-1]};
  assign sel_cur    = div_pend_r ? rem_r[SEL_W-1:0] : sel_r;

  assign stat.need_div = (kind_r == KIND_POLL) && moved && !playing_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      rguard_r <= ROT_GUARD_RST;
      bguard_r <= BTN_GUARD_RST;
      vstep_r  <= VOL_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PLAYLIST_COUNT: pc_r     <= cfg_wdata[PC_W-1:0];
        CFG_ROTATE_GUARD:   rguard_r <= cfg_wdata[RG_W-1:0];
        CFG_BUTTON_GUARD:   bguard_r <= cfg_wdata[BG_W-1:0];
        CFG_VOLUME_STEP:    vstep_r  <= cfg_wdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted event
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r   <= kind_t'(in_kind);
      now_r    <= in_now_ms;
      clk_lv_r <= in_clk_level;
      dt_lv_r  <= in_dt_level;
    end
  end

  // Knob, button and playback state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      polled_r     <= '0;
      prev_clk_r   <= 1'b0;
      turn_time_r  <= '0;
      press_time_r <= '0;
      pending_r    <= 1'b0;
      vol_r        <= VOL_RST;
      sel_r        <= '0;
      playing_r    <= 1'b0;
      start_r      <= 1'b0;
      stop_r       <= 1'b0;
      refresh_r    <= 1'b0;
      div_pend_r   <= 1'b0;
    end else if (cmd.exec) begin
      start_r    <= 1'b0;
      stop_r     <= 1'b0;
      refresh_r  <= 1'b0;
      div_pend_r <= 1'b0;
      unique case (kind_r)
        KIND_TURN: begin
          // drop changes inside the rotate guard
          if (turn_diff >= TIME_W'(rguard_r)) begin
            if (clk_lv_r != prev_clk_r) begin
              count_r     <= (clk_lv_r != dt_lv_r) ? count_r + 1'b1 : count_r - 1'b1;
              turn_time_r <= now_r;
            end
            prev_clk_r <= clk_lv_r;
          end
        end
        KIND_PRESS: begin
          if (press_diff > TIME_W'(bguard_r)) begin
            pending_r <= 1'b1;
          end
          press_time_r <= now_r;
        end
        KIND_POLL: begin
          if (moved) begin
            if (playing_r) begin
              if (down) begin
                vol_r <= (vol_r > vstep_r) ? vol_r - vstep_r : '0;
              end else begin
                vol_r <= (vol_up > {1'b0, VOL_MAX}) ? VOL_MAX : vol_up[VOL_W-1:0];
              end
            end else begin
              div_pend_r <= 1'b1;
            end
            polled_r  <= count_r;
            refresh_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd.post) begin
      sel_r      <= sel_cur;
      div_pend_r <= 1'b0;
      // consume a pending press at a poll
      if ((kind_r == KIND_POLL) && pending_r) begin
        pending_r <= 1'b0;
        refresh_r <= 1'b1;
        if ((pc_r != '0) && (sel_cur < pc_r)) begin
          playing_r <= !playing_r;
          stop_r    <= playing_r;
          start_r   <= !playing_r;
        end
      end
    end
  end

  // Remainder of the stepped selection, one dividend bit per step
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      dvd_r <= down ? DVD_W'(sel_r) + DVD_W'(n_eff) - 1'b1 : DVD_W'(sel_r) + 1'b1;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= (shifted >= DVD_W'(n_eff)) ? shifted - DVD_W'(n_eff) : shifted;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_volume_now    <= vol_r;
      out_selection_now <= sel_r[SELO_W-1:0];
      out_playing_now   <= playing_r;
      out_knob_count    <= count_r;
      out_start_request <= start_r;
      out_stop_request  <= stop_r;
      out_refresh       <= refresh_r;
    end
  end

endmodule : rkvs_dp
`default_nettype wire

@@ rtl/rotary_knob_volume_selector_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_knob_volume_selector_top: rotary knob volume and playlist selector
// Decodes timestamped knob events and polls into volume, selection and
// play/stop status, one result per event.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    kind, now_ms, clk_level, dt_level
//   out_     output     out_valid/out_ready  volume, selection, playing, count,
//                                            start/stop requests, refresh
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// An event passes through accept, execute, press handling and output load, in
// that order; a poll that steps the selection adds the bit-serial remainder
// unit between execute and press handling, one step per dividend bit.
// One event is in flight at a time; the next one is taken while the previous
// result still waits in the output register.
// A stalled output holds the sequencer in its final state until the register
// frees up. Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rotary_knob_volume_selector_top
  import rkvs_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFGI_W-1:0]       cfg_index,
  input  wire logic [CFGD_W-1:0]       cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [KIND_W-1:0]       in_kind,
  input  wire logic [TIME_W-1:0]       in_now_ms,
  input  wire logic                    in_clk_level,
  input  wire logic                    in_dt_level,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [VOL_W-1:0]             out_volume_now,
  output logic [SELO_W-1:0]            out_selection_now,
  output logic                         out_playing_now,
  output logic signed [COUNT_BITS-1:0] out_knob_count,
  output logic                         out_start_request,
  output logic                         out_stop_request,
  output logic                         out_refresh
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  rkvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // State and arithmetic
  rkvs_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_kind),
    .in_now_ms         (in_now_ms),
    .in_clk_level      (in_clk_level),
    .in_dt_level       (in_dt_level),
    .out_volume_now    (out_volume_now),
    .out_selection_now (out_selection_now),
    .out_playing_now   (out_playing_now),
    .out_knob_count    (out_knob_count),
    .out_start_request (out_start_request),
    .out_stop_request  (out_stop_request),
    .out_refresh       (out_refresh)
  );

endmodule : rotary_knob_volume_selector_top
`default_nettype wire
